@@ rtl/tzg_pkg.sv @@
package tzg_pkg;

  // Q9.8 temperature word
  localparam int unsigned TEMP_W = 17;
  localparam logic [TEMP_W-1:0] TEMP_SCALE = 17'd84480;  // 330 * 256
  localparam logic [TEMP_W-1:0] AVG_RESET  = 17'd6400;   // 25 C

  // smoothing weight, Q1.8
  localparam int unsigned WEIGHT_W = 9;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 9'd256;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd51;

  localparam logic [TEMP_W-1:0] WARN_RESET = 17'd15360;  // 60 C
  localparam logic [TEMP_W-1:0] CRIT_RESET = 17'd17920;  // 70 C

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = TEMP_W;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_WEIGHT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WARNING_LEVEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_LEVEL = 2'd2;

  // zones
  localparam int unsigned NUM_ZONES   = 3;
  localparam int unsigned ZONE_SERVO   = 0;
  localparam int unsigned ZONE_BATTERY = 1;
  localparam int unsigned ZONE_BUCK    = 2;

  typedef enum logic [1:0] {
    ALARM_NORMAL   = 2'd0,
    ALARM_WARNING  = 2'd1,
    ALARM_CRITICAL = 2'd2
  } alarm_e;

endpackage

@@ rtl/tzg_in_if.sv @@
interface tzg_in_if #(
  parameter int unsigned SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] servo_raw;
  logic [SAMPLE_BITS-1:0] battery_raw;
  logic [SAMPLE_BITS-1:0] buck_raw;

  modport source (
    output valid, servo_raw, battery_raw, buck_raw,
    input  ready
  );
  modport sink (
    input  valid, servo_raw, battery_raw, buck_raw,
    output ready
  );
endinterface

@@ rtl/tzg_out_if.sv @@
interface tzg_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  alarm_level;
  logic [tzg_pkg::TEMP_W-1:0]  servo_smoothed;
  logic [tzg_pkg::TEMP_W-1:0]  battery_smoothed;
  logic [tzg_pkg::TEMP_W-1:0]  buck_smoothed;
  logic [tzg_pkg::TEMP_W-1:0]  hottest_zone_temp;

  modport source (
    output valid, alarm_level, servo_smoothed, battery_smoothed, buck_smoothed,
           hottest_zone_temp,
    input  ready
  );
  modport sink (
    input  valid, alarm_level, servo_smoothed, battery_smoothed, buck_smoothed,
           hottest_zone_temp,
    output ready
  );
endinterface

@@ rtl/tzg_scale.sv @@
module tzg_scale #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic [SAMPLE_BITS-1:0]     raw_i,
  output logic [tzg_pkg::TEMP_W-1:0] temp_o
);
  import tzg_pkg::*;

  // temp = floor(raw * 84480 / (2^n - 1)). Since 2^n = 1 mod (2^n - 1),
  // fold the high part onto the low part; three folds leave a rest below
  // twice the divisor, so one compare finishes it.
  localparam int unsigned XW    = SAMPLE_BITS + TEMP_W;
  localparam int unsigned FS    = (1 << SAMPLE_BITS) - 1;
  localparam int unsigned FOLDS = 2;

  logic [XW-1:0] prod;
  logic [17:0]   acc;
  logic [17:0]   hi;
  logic [17:0]   rest;

  always_comb begin
    prod = XW'(raw_i) * XW'(TEMP_SCALE);
    acc  = 18'(prod >> SAMPLE_BITS);
    rest = 18'(prod >> SAMPLE_BITS) + 18'(prod & XW'(FS));
    hi   = '0;
    for (int k = 0; k < FOLDS; k++) begin
      hi   = rest >> SAMPLE_BITS;
      acc  = acc + hi;
      rest = hi + (rest & 18'(FS));
    end
    if (rest >= 18'(FS)) begin
      acc = acc + 18'd1;
    end
    temp_o = acc[TEMP_W-1:0];
  end

endmodule

@@ rtl/tzg_ema.sv @@
module tzg_ema (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         upd_i,
  input  logic [tzg_pkg::WEIGHT_W-1:0] weight_i,
  input  logic [tzg_pkg::TEMP_W-1:0]   temp_i,
  output logic [tzg_pkg::TEMP_W-1:0]   avg_o
);
  import tzg_pkg::*;

  logic [TEMP_W-1:0]   avg_q, avg_d;
  logic [9:0]          alpha;
  logic signed [17:0]  diff;
  logic signed [28:0]  prod;
  logic signed [18:0]  step;
  logic signed [18:0]  sum;

  // avg += floor(alpha * (temp - avg) / 256); weights above one clamp to one
  always_comb begin
    alpha = (weight_i > WEIGHT_ONE) ? 10'(WEIGHT_ONE) : {1'b0, weight_i};
    diff  = $signed({1'b0, temp_i}) - $signed({1'b0, avg_q});
    prod  = $signed({1'b0, alpha}) * diff;
    step  = prod[26:8];  // arithmetic shift floors
    sum   = $signed({2'b00, avg_q}) + step;
    avg_d = sum[TEMP_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= AVG_RESET;
    end else if (upd_i) begin
      avg_q <= avg_d;
    end
  end

  assign avg_o = avg_q;

endmodule

@@ rtl/three_zone_thermal_guard_core.sv @@
// Three-zone thermal guard. Each input word is one sampling tick with three
// raw converter readings; each is scaled to Q9.8 degrees C, run through its
// own exponential moving average (weight filter_weight/256, clamped to one),
// and the hottest average is graded against critical_level and
// warning_level (critical checked first). One result word leaves for every
// input word. The datapath is a four-stage pipeline: input register,
// temperature register (after the scaling unit), the average registers
// (which are the filter state), and the result register. A new word is taken
// every cycle while sample_i.ready is high; a result passes through those
// four registers in order. Back-pressure fills the stages one at a time, so
// up to four words are held before sample_i.ready drops. The average update
// is the only loop: a 10x18 multiply and an add. Configuration writes go
// straight into the registers and are meant for while the pipe is empty.
module three_zone_thermal_guard_core #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tzg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tzg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  tzg_in_if.sink                         sample_i,
  tzg_out_if.source                      result_o
);
  import tzg_pkg::*;

  // configuration registers
  logic [WEIGHT_W-1:0] weight_q;
  logic [TEMP_W-1:0]   warn_q;
  logic [TEMP_W-1:0]   crit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WEIGHT_RESET;
      warn_q   <= WARN_RESET;
      crit_q   <= CRIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FILTER_WEIGHT:  weight_q <= cfg_wdata_i[WEIGHT_W-1:0];
        REG_WARNING_LEVEL:  warn_q   <= cfg_wdata_i[TEMP_W-1:0];
        REG_CRITICAL_LEVEL: crit_q   <= cfg_wdata_i[TEMP_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // pipeline handshake: each stage takes a word when empty or draining
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic s1_rdy, s2_rdy, s3_rdy, out_rdy;

  assign out_rdy = !out_valid_q || result_o.ready;
  assign s3_rdy  = !s3_valid_q  || out_rdy;
  assign s2_rdy  = !s2_valid_q  || s3_rdy;
  assign s1_rdy  = !s1_valid_q  || s2_rdy;

  assign sample_i.ready = s1_rdy;

  logic s1_load, s2_load, s3_upd, out_load;
  assign s1_load  = sample_i.valid && s1_rdy;
  assign s2_load  = s1_valid_q && s2_rdy;
  assign s3_upd   = s2_valid_q && s3_rdy;
  assign out_load = s3_valid_q && out_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_rdy)  s1_valid_q  <= sample_i.valid;
      if (s2_rdy)  s2_valid_q  <= s1_valid_q;
      if (s3_rdy)  s3_valid_q  <= s2_valid_q;
      if (out_rdy) out_valid_q <= s3_valid_q;
    end
  end

  // stage 1: raw input register
  logic [SAMPLE_BITS-1:0] raw_q [NUM_ZONES];

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      raw_q[ZONE_SERVO]   <= sample_i.servo_raw;
      raw_q[ZONE_BATTERY] <= sample_i.battery_raw;
      raw_q[ZONE_BUCK]    <= sample_i.buck_raw;
    end
  end

  // stage 2: scaled temperatures; stage 3: per-zone averages
  logic [TEMP_W-1:0] temp_d [NUM_ZONES];
  logic [TEMP_W-1:0] temp_q [NUM_ZONES];
  logic [TEMP_W-1:0] avg    [NUM_ZONES];

  for (genvar z = 0; z < NUM_ZONES; z++) begin : g_zone
    tzg_scale #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
      .raw_i  (raw_q[z]),
      .temp_o (temp_d[z])
    );

    always_ff @(posedge clk_i) begin
      if (s2_load) begin
        temp_q[z] <= temp_d[z];
      end
    end

    tzg_ema u_ema (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .upd_i    (s3_upd),
      .weight_i (weight_q),
      .temp_i   (temp_q[z]),
      .avg_o    (avg[z])
    );
  end

  // stage 4: hottest zone and grading
  logic [TEMP_W-1:0] hot_d;
  alarm_e            alarm_d;

  always_comb begin
    hot_d = avg[ZONE_SERVO];
    if (avg[ZONE_BATTERY] > hot_d) hot_d = avg[ZONE_BATTERY];
    if (avg[ZONE_BUCK] > hot_d)    hot_d = avg[ZONE_BUCK];
    if (hot_d >= crit_q) begin
      alarm_d = ALARM_CRITICAL;
    end else if (hot_d >= warn_q) begin
      alarm_d = ALARM_WARNING;
    end else begin
      alarm_d = ALARM_NORMAL;
    end
  end

  alarm_e            alarm_q;
  logic [TEMP_W-1:0] smooth_q [NUM_ZONES];
  logic [TEMP_W-1:0] hot_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      alarm_q  <= alarm_d;
      smooth_q <= avg;
      hot_q    <= hot_d;
    end
  end

  assign result_o.valid             = out_valid_q;
  assign result_o.alarm_level       = alarm_q;
  assign result_o.servo_smoothed    = smooth_q[ZONE_SERVO];
  assign result_o.battery_smoothed  = smooth_q[ZONE_BATTERY];
  assign result_o.buck_smoothed     = smooth_q[ZONE_BUCK];
  assign result_o.hottest_zone_temp = hot_q;

  // filter state moves only when a word enters the averaging stage
  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s3_upd |=> ($stable(avg[ZONE_SERVO]) && $stable(avg[ZONE_BATTERY]) &&
                 $stable(avg[ZONE_BUCK])))
    else $error("filter state changed without an update");

  // input is refused only when every stage holds a word
  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_i.ready |-> (s1_valid_q && s2_valid_q && s3_valid_q && out_valid_q))
    else $error("input stalled with an empty stage");

  // reported hottest value dominates all three zones
  a_hottest_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (hot_q >= smooth_q[ZONE_SERVO] &&
                        hot_q >= smooth_q[ZONE_BATTERY] &&
                        hot_q >= smooth_q[ZONE_BUCK]))
    else $error("hottest value below a zone average");

  // critical grade only at or above the critical threshold
  a_crit_grade : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && alarm_q == ALARM_CRITICAL) |-> (hot_q >= crit_q))
    else $error("critical grade below threshold");

endmodule
